// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of the deframer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/fsd_pkg.sv -----
// ---------------------------------------------------------------------------
// Fiber sample deframer package
// Constants and types shared by the deframer modules and interfaces.
// ---------------------------------------------------------------------------
`default_nettype none

package fsd_pkg;

	localparam int WORD_W       = 32;
	localparam int CHANNEL_W    = 4;
	localparam int ADC_W        = 8;
	localparam int TDC_W        = 7;
	localparam int CAP_ID_W     = 2;
	localparam int NUM_CHANNELS = 8;
	localparam int IDX_W        = 3;
	localparam int COUNT_W      = 4;
	localparam int SAMPLE_LEN   = 11;
	localparam int COUNT_SAT    = 12;

	localparam logic [7:0]  DELIM_BYTE  = 8'hbc;
	localparam logic [15:0] IDLE_HALF_A = 16'hf7fb;
	localparam logic [15:0] IDLE_HALF_B = 16'hbc7c;

	typedef logic [7:0] byte_t;

	// One decoded sample, ready for the result sequencer.
	typedef struct packed {
		byte_t                              header;
		logic [NUM_CHANNELS-1:0][ADC_W-1:0] adc;
		logic [2*NUM_CHANNELS-1:0]          tdc_codes;
		logic                               cap_id_skip;
	} frame_t;

endpackage

`default_nettype wire

// ----- rtl/fsd_if.sv -----
// ---------------------------------------------------------------------------
// Fiber sample deframer channels
// Valid/ready interfaces for fiber words in and channel results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface fsd_word_if;
	import fsd_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] fiber_word;
	logic              last_word;

	modport source (output valid, output fiber_word, output last_word, input ready);
	modport sink   (input valid, input fiber_word, input last_word, output ready);
endinterface

interface fsd_result_if;
	import fsd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CHANNEL_W-1:0] channel;
	logic [ADC_W-1:0]     adc_value;
	logic [TDC_W-1:0]     tdc_value;
	logic [CAP_ID_W-1:0]  cap_id;
	logic                 crc_error;
	logic                 bunch_zero;
	logic                 cap_id_skip;
	logic                 last_of_frame;

	modport source (
		output valid, output channel, output adc_value, output tdc_value,
		output cap_id, output crc_error, output bunch_zero, output cap_id_skip,
		output last_of_frame, input ready
	);
	modport sink (
		input valid, input channel, input adc_value, input tdc_value,
		input cap_id, input crc_error, input bunch_zero, input cap_id_skip,
		input last_of_frame, output ready
	);
endinterface

`default_nettype wire

// ----- rtl/fiber_sample_deframer.sv -----
// ---------------------------------------------------------------------------
// Fiber sample deframer
// Splits a fiber word stream into 11-byte samples and decodes each one.
// ---------------------------------------------------------------------------
// The block takes one 32-bit fiber word per transaction and can accept a new
// word in every cycle unless the word register is held. Words that close no
// valid sample pass straight through the word register and leave only their
// bytes behind in the sample store. Each decoded sample yields eight channel
// results, one per cycle on the output port while the receiver is ready, so
// the result sequencer sets the sustained rate. A word that completes a
// sample waits in the word register while the sequencer is still sending
// the previous sample, and no word is accepted in that time. Its results
// pass through the sequencer's sample registers and its output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fiber_sample_deframer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [fsd_pkg::CHANNEL_W-1:0] cfg_data,
	fsd_word_if.sink                           words,
	fsd_result_if.source                       results
);
	import fsd_pkg::*;

	// The channel offset register. The user must write it only while the block is
	// idle, which the block does not enforce, so that the sequencer may read it directly.
	logic [CHANNEL_W-1:0] channel_base_q;

	// Decoded sample travelling from the splitter to the sequencer.
	frame_t frame;
	logic   frame_valid;
	logic   frame_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_base_q <= '0;
		end else if (cfg_we) begin
			channel_base_q <= cfg_data;
		end
	end

	// The splitter holds the open sample, the byte count and the cap id
	// history. It drops idle halves, breaks samples at delimiter bytes and
	// at the end of the stream, and hands on every sample of exactly eleven
	// bytes together with its cap id skip flag.
	fsd_splitter u_splitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.words       (words),
		.frame       (frame),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready)
	);

	// The sequencer holds one decoded sample and sends its eight channel
	// results through an output register. It takes the next sample in the
	// same cycle as it loads the eighth result of the current one into that register.
	fsd_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame        (frame),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.channel_base (channel_base_q),
		.results      (results)
	);

	// A sample offered to the sequencer must wait unchanged until taken.
	`ASSERT_PROP(a_frame_hold, clk, arst_n, frame_valid && !frame_ready |=> frame_valid && $stable(frame), "decoded sample changed while waiting")

	// The eighth result of a sample belongs to the last channel of the fiber.
	`ASSERT_PROP(a_last_channel, clk, arst_n, results.valid && results.last_of_frame |-> results.channel == CHANNEL_W'(channel_base_q + CHANNEL_W'(NUM_CHANNELS - 1)), "last result on wrong channel")

	// Every TDC value is a non-zero multiple of sixteen.
	`ASSERT_NEVER(a_tdc_form, clk, arst_n, results.valid && (results.tdc_value[3:0] != 4'd0 || results.tdc_value == 7'd0), "malformed TDC value")

endmodule

`default_nettype wire

// ----- rtl/fsd_splitter.sv -----
// ---------------------------------------------------------------------------
// Fiber sample deframer word splitter
// Registers each fiber word, splits it into bytes and assembles samples.
// ---------------------------------------------------------------------------
`default_nettype none

module fsd_splitter (
	input  wire logic          clk,
	input  wire logic          arst_n,
	fsd_word_if.sink           words,
	output fsd_pkg::frame_t    frame,
	output logic               frame_valid,
	input  wire logic          frame_ready
);
	import fsd_pkg::*;

	logic                         valid_s1;
	logic [WORD_W-1:0]            word_s1;
	logic                         last_s1;

	logic [COUNT_W-1:0]           count_q;
	logic [SAMPLE_LEN-1:0][7:0]   stash_q;
	logic [CAP_ID_W-1:0]          prev_cap_q;
	logic                         have_prev_q;

	logic [COUNT_W-1:0]           count_next;
	logic [SAMPLE_LEN-1:0][7:0]   stash_next;
	logic [SAMPLE_LEN-1:0][7:0]   snap;
	logic                         decode;
	logic                         advance;

	// Walk the up to four bytes of the word in stream order.
	always_comb begin
		logic [3:0][7:0] lanes;
		logic [3:0]      keep;
		logic            keep_lo;
		logic            keep_hi;
		keep_lo    = (word_s1[15:0] != IDLE_HALF_A) && (word_s1[15:0] != IDLE_HALF_B);
		keep_hi    = (word_s1[31:16] != IDLE_HALF_A) && (word_s1[31:16] != IDLE_HALF_B);
		keep       = {keep_hi, keep_hi, keep_lo, keep_lo};
		lanes      = {word_s1[23:16], word_s1[31:24], word_s1[7:0], word_s1[15:8]};
		count_next = count_q;
		stash_next = stash_q;
		snap       = stash_q;
		decode     = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (keep[k]) begin
				if (lanes[k] == DELIM_BYTE) begin
					if (count_next == COUNT_W'(SAMPLE_LEN) && !decode) begin
						decode = 1'b1;
						snap   = stash_next;
					end
					count_next = '0;
				end else begin
					if (count_next < COUNT_W'(SAMPLE_LEN))
						stash_next[count_next] = lanes[k];
					if (count_next < COUNT_W'(COUNT_SAT))
						count_next = count_next + COUNT_W'(1);
				end
			end
		end
		if (last_s1) begin
			if (count_next == COUNT_W'(SAMPLE_LEN) && !decode) begin
				decode = 1'b1;
				snap   = stash_next;
			end
			count_next = '0;
		end
	end

	always_comb begin
		frame.header      = snap[0];
		frame.adc         = snap[8:1];
		frame.tdc_codes   = {snap[10], snap[9]};
		frame.cap_id_skip = have_prev_q && ((prev_cap_q + CAP_ID_W'(1)) != snap[0][3:2]);
	end

	assign frame_valid = valid_s1 && decode;
	assign advance     = valid_s1 && (!decode || frame_ready);
	assign words.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			count_q     <= '0;
			prev_cap_q  <= '0;
			have_prev_q <= 1'b0;
		end else begin
			if (words.ready)
				valid_s1 <= words.valid;
			if (advance) begin
				count_q <= count_next;
				if (last_s1) begin
					prev_cap_q  <= '0;
					have_prev_q <= 1'b0;
				end else if (decode) begin
					prev_cap_q  <= snap[0][3:2];
					have_prev_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (words.valid && words.ready) begin
			word_s1 <= words.fiber_word;
			last_s1 <= words.last_word;
		end
		if (advance)
			stash_q <= stash_next;
	end

endmodule

`default_nettype wire

// ----- rtl/fsd_emitter.sv -----
// ---------------------------------------------------------------------------
// Fiber sample deframer result sequencer
// Holds one decoded sample and sends its eight channel results in turn.
// ---------------------------------------------------------------------------
`default_nettype none

module fsd_emitter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fsd_pkg::frame_t               frame,
	input  wire logic                          frame_valid,
	output logic                               frame_ready,
	input  wire logic [fsd_pkg::CHANNEL_W-1:0] channel_base,
	fsd_result_if.source                       results
);
	import fsd_pkg::*;

	logic                               held_q;
	logic [IDX_W-1:0]                   idx_q;
	byte_t                              header_q;
	logic [NUM_CHANNELS-1:0][ADC_W-1:0] adc_q;
	logic [2*NUM_CHANNELS-1:0]          tdc_q;
	logic                               skip_q;
	logic                               out_valid_q;
	logic                               load;
	logic                               final_one;

	assign load        = held_q && (!out_valid_q || results.ready);
	assign final_one   = (idx_q == IDX_W'(NUM_CHANNELS - 1));
	assign frame_ready = !held_q || (load && final_one);
	assign results.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
			if (frame_valid && frame_ready) begin
				held_q <= 1'b1;
				idx_q  <= '0;
			end else if (load) begin
				idx_q <= idx_q + IDX_W'(1);
				if (final_one)
					held_q <= 1'b0;
			end
		end
	end

	// The sample shifts down one channel per result sent.
	always_ff @(posedge clk) begin
		if (frame_valid && frame_ready) begin
			header_q <= frame.header;
			adc_q    <= frame.adc;
			tdc_q    <= frame.tdc_codes;
			skip_q   <= frame.cap_id_skip;
		end else if (load) begin
			adc_q <= {ADC_W'(0), adc_q[NUM_CHANNELS-1:1]};
			tdc_q <= {2'b00, tdc_q[2*NUM_CHANNELS-1:2]};
		end
		if (load) begin
			results.channel       <= CHANNEL_W'(channel_base + CHANNEL_W'(idx_q));
			results.adc_value     <= adc_q[0];
			results.tdc_value     <= {3'({1'b0, tdc_q[1:0]} + 3'd1), 4'b0000};
			results.cap_id        <= header_q[3:2];
			results.crc_error     <= header_q[1];
			results.bunch_zero    <= header_q[0];
			results.cap_id_skip   <= skip_q;
			results.last_of_frame <= final_one;
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/tb_fiber_sample_deframer.sv -----
// ---------------------------------------------------------------------------
// Fiber sample deframer testbench
// Feeds framed fiber word streams to the deframer, predicts every channel
// result from a behavioural copy of the sample store, and checks the
// results in order, with random stalls on both handshakes in all but the last phase.
// ---------------------------------------------------------------------------

// One channel result, laid out field by field as the result port carries it.
typedef struct packed {
	logic [fsd_pkg::CHANNEL_W-1:0] channel;
	logic [fsd_pkg::ADC_W-1:0]     adc_value;
	logic [fsd_pkg::TDC_W-1:0]     tdc_value;
	logic [fsd_pkg::CAP_ID_W-1:0]  cap_id;
	logic                          crc_error;
	logic                          bunch_zero;
	logic                          cap_id_skip;
	logic                          last_of_frame;
} channel_result_t;

class sample_scoreboard;
	fsd_pkg::byte_t             sample_store [fsd_pkg::SAMPLE_LEN];
	logic [fsd_pkg::COUNT_W-1:0] fill;
	logic [1:0]                 prior_cap_id;
	bit                         prior_cap_valid;
	logic [3:0]                 channel_base;
	channel_result_t            channels_due [$];
	int                         errors;

	function new();
		foreach (sample_store[i]) sample_store[i] = '0;
		fill            = '0;
		prior_cap_id    = '0;
		prior_cap_valid = 0;
		channel_base    = '0;
		errors          = 0;
	endfunction

	// Closes the open sample; only an exact eleven-byte sample is decoded.
	function void close_sample();
		channel_result_t r;
		fsd_pkg::byte_t  header;
		fsd_pkg::byte_t  codes;
		logic [1:0]      cap;
		logic [1:0]      code;
		logic            skip;
		int              i;
		if (fill == fsd_pkg::COUNT_W'(fsd_pkg::SAMPLE_LEN)) begin
			header = sample_store[0];
			cap    = header[3:2];
			skip   = prior_cap_valid && (cap != prior_cap_id + 2'd1);
			for (i = 0; i < fsd_pkg::NUM_CHANNELS; i++) begin
				codes             = sample_store[i < 4 ? 9 : 10];
				code              = codes[2*(i%4) +: 2];
				r.channel         = channel_base + 4'(i);
				r.adc_value       = sample_store[1+i];
				r.tdc_value       = {code + 3'd1, 4'b0000};
				r.cap_id          = cap;
				r.crc_error       = header[1];
				r.bunch_zero      = header[0];
				r.cap_id_skip     = skip;
				r.last_of_frame   = (i == fsd_pkg::NUM_CHANNELS - 1);
				channels_due      = {channels_due, r};
			end
			prior_cap_id    = cap;
			prior_cap_valid = 1;
		end
		fill = '0;
	endfunction

	function void take_byte(fsd_pkg::byte_t b);
		if (b == fsd_pkg::DELIM_BYTE) begin
			close_sample();
		end else begin
			if (fill < fsd_pkg::SAMPLE_LEN) sample_store[fill] = b;
			if (fill < fsd_pkg::COUNT_SAT) fill++;
		end
	endfunction

	// Notes one accepted fiber word: low half first, idle halves skipped.
	function void absorb_word(logic [fsd_pkg::WORD_W-1:0] word, logic last);
		logic [15:0] half;
		int          h;
		for (h = 0; h < 2; h++) begin
			half = word[16*h +: 16];
			if (half != fsd_pkg::IDLE_HALF_A && half != fsd_pkg::IDLE_HALF_B) begin
				take_byte(half[15:8]);
				take_byte(half[7:0]);
			end
		end
		if (last) begin
			close_sample();
			prior_cap_id    = '0;
			prior_cap_valid = 0;
		end
	endfunction

	task report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task compare_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task check_result(channel_result_t got);
		channel_result_t want;
		if (channels_due.size() == 0) begin
			report_mismatch($sformatf("result on channel %0d with none expected", got.channel));
			return;
		end
		want = channels_due.pop_front();
		compare_field("channel", 8'(got.channel), 8'(want.channel));
		compare_field("adc_value", got.adc_value, want.adc_value);
		compare_field("tdc_value", 8'(got.tdc_value), 8'(want.tdc_value));
		compare_field("cap_id", 8'(got.cap_id), 8'(want.cap_id));
		compare_field("crc_error", 8'(got.crc_error), 8'(want.crc_error));
		compare_field("bunch_zero", 8'(got.bunch_zero), 8'(want.bunch_zero));
		compare_field("cap_id_skip", 8'(got.cap_id_skip), 8'(want.cap_id_skip));
		compare_field("last_of_frame", 8'(got.last_of_frame), 8'(want.last_of_frame));
	endtask
endclass

module tb_fiber_sample_deframer;
	import fsd_pkg::*;

	// The watchdog ends the run after this many cycles without any transaction.
	// The longest honest quiet stretch is a drain pause plus a stall burst.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS    = 100;
	// This settling margin covers words still being absorbed when the last
	// result has gone.
	localparam int SETTLE_CYCLES  = 6;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CHANNEL_W-1:0] cfg_data = '0;

	fsd_word_if   words_if ();
	fsd_result_if results_if ();

	fiber_sample_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.words    (words_if),
		.results  (results_if)
	);

	sample_scoreboard sb = new();

	// Stream generator state: bytes still to be packed into words, whether
	// the stream is to end once they are gone, and the cap id last framed.
	byte_t      stream_bytes [$];
	bit         stream_ends;
	bit         auto_segments;
	bit         idle_on;
	logic [1:0] framed_cap;
	int         stall_left;
	int         quiet_cycles;

	always #4 clk = ~clk;

	// The result side holds ready low in random bursts while idling is
	// enabled, and keeps it high otherwise.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			results_if.ready = 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 6) == 0) begin
			results_if.ready = 1'b0;
			stall_left = $urandom_range(0, 3);
		end else begin
			results_if.ready = 1'b1;
		end
	end

	// Every result transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			sb.check_result('{
				channel:       results_if.channel,
				adc_value:     results_if.adc_value,
				tdc_value:     results_if.tdc_value,
				cap_id:        results_if.cap_id,
				crc_error:     results_if.crc_error,
				bunch_zero:    results_if.bunch_zero,
				cap_id_skip:   results_if.cap_id_skip,
				last_of_frame: results_if.last_of_frame
			});
	end

	// The watchdog restarts on any transaction in either direction.
	always @(posedge clk) begin
		if (!arst_n || (words_if.valid && words_if.ready)
				|| (results_if.valid && results_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Adds one byte to the end of the pending stream.
	function automatic void append_byte(byte_t b);
		stream_bytes = {stream_bytes, b};
	endfunction

	// A random byte that is never the delimiter, for sample contents.
	function automatic byte_t data_byte();
		byte_t b;
		b = byte_t'($urandom);
		if (b == DELIM_BYTE) b ^= 8'h01;
		return b;
	endfunction

	// Ten payload bytes: the eight ADC bytes then the two TDC code bytes,
	// the first byte in the low bits.
	function automatic logic [79:0] random_body();
		logic [79:0] body;
		int          i;
		for (i = 0; i < 10; i++) body[8*i +: 8] = data_byte();
		return body;
	endfunction

	// Mostly the next cap id in turn, sometimes any; the top nibble and the
	// flag bits are random, but the header itself never reads as a delimiter.
	function automatic byte_t next_header();
		byte_t hdr;
		if ($urandom_range(0, 3) != 0) framed_cap = framed_cap + 2'd1;
		else framed_cap = 2'($urandom);
		hdr = {4'($urandom), framed_cap, 2'($urandom)};
		if (hdr == DELIM_BYTE) hdr[7:4] = 4'h0;
		return hdr;
	endfunction

	function automatic void push_sample(byte_t hdr, logic [79:0] body);
		int i;
		append_byte(hdr);
		for (i = 0; i < 10; i++) append_byte(body[8*i +: 8]);
	endfunction

	function automatic void push_data(int n);
		int i;
		for (i = 0; i < n; i++) append_byte(data_byte());
	endfunction

	// Appends one stretch of stream. Most of it is well-formed samples, so the
	// decoder is exercised deeply; the rest is short, overlong and raw noise.
	function automatic void add_segment();
		int kind;
		int i;
		kind = $urandom_range(0, 99);
		if (kind < 12 && stream_bytes.size() == 0) begin
			// A sample that only the end of the stream closes. The leading
			// delimiter keeps the whole stretch an even number of bytes.
			append_byte(DELIM_BYTE);
			push_sample(next_header(), random_body());
			stream_ends = 1;
		end else if (kind < 80) begin
			push_sample(next_header(), random_body());
			append_byte(DELIM_BYTE);
			if ($urandom_range(0, 9) == 0)
				for (i = $urandom_range(1, 3); i > 0; i--) append_byte(DELIM_BYTE);
		end else if (kind < 88) begin
			push_data($urandom_range(0, 10));
			append_byte(DELIM_BYTE);
		end else if (kind < 94) begin
			push_data($urandom_range(12, 15));
			append_byte(DELIM_BYTE);
		end else begin
			for (i = $urandom_range(1, 6); i > 0; i--) append_byte(byte_t'($urandom));
		end
	endfunction

	// Packs the next word from the pending bytes, sprinkling idle halves.
	function automatic void next_word(output logic [WORD_W-1:0] word, output logic last);
		logic [15:0] half;
		byte_t       hi;
		int          h;
		for (h = 0; h < 2; h++) begin
			if ($urandom_range(0, 11) == 0) begin
				half = $urandom_range(0, 1) ? IDLE_HALF_A : IDLE_HALF_B;
			end else begin
				if (stream_bytes.size() < 2 && auto_segments && !stream_ends) add_segment();
				if (stream_bytes.size() < 2) begin
					half = IDLE_HALF_A;
				end else begin
					hi   = stream_bytes.pop_front();
					half = {hi, stream_bytes.pop_front()};
				end
			end
			word[16*h +: 16] = half;
		end
		last = stream_ends && stream_bytes.size() == 0;
		if (last) begin
			stream_ends = 0;
		end else if (auto_segments && $urandom_range(0, 79) == 0) begin
			// An end of stream in the middle of whatever was being framed.
			last = 1;
			stream_bytes.delete();
		end
	endfunction

	// Offers one word from a falling edge and returns at the falling edge
	// after its transaction, with valid still high so that a following word
	// can be offered without a gap.
	task automatic send_word(input logic [WORD_W-1:0] word, input logic last);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			words_if.valid = 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		words_if.valid      = 1'b1;
		words_if.fiber_word = word;
		words_if.last_word  = last;
		do @(posedge clk); while (!words_if.ready);
		sb.absorb_word(word, last);
		@(negedge clk);
	endtask

	task automatic send_pending();
		logic [WORD_W-1:0] word;
		logic              last;
		while (stream_bytes.size() != 0) begin
			next_word(word, last);
			send_word(word, last);
		end
	endtask

	// Holds the word side idle until every predicted result has arrived,
	// then lets the block settle.
	task automatic drain_results();
		words_if.valid = 1'b0;
		while (sb.channels_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_channel_base(input logic [CHANNEL_W-1:0] value);
		drain_results();
		cfg_we   = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.channel_base = value;
	endtask

	// Short hand-made stream covering the corners of the format.
	task automatic directed_stream();
		// Two words of idle halves only: nothing reaches the sample store.
		send_word({IDLE_HALF_A, IDLE_HALF_B}, 1'b0);
		send_word({IDLE_HALF_B, IDLE_HALF_A}, 1'b0);
		// First sample of the stream: cap id 3 with both flags set, ADC bytes
		// at both extremes, and all TDC codes zero then all three.
		push_sample(8'h0f, 80'hff_00_aa_55_fe_7f_80_01_ff_00);
		append_byte(DELIM_BYTE);
		// Header bits 7:4 set and ignored; cap id wraps from 3 to 0; one of
		// each TDC code in each code byte.
		push_sample(8'hf0, 80'h1b_e4_12_34_56_78_9a_bd_de_f1);
		append_byte(DELIM_BYTE);
		// In sequence, then a skipped cap id.
		push_sample(8'h06, random_body());
		append_byte(DELIM_BYTE);
		push_sample(8'h0c, random_body());
		append_byte(DELIM_BYTE);
		// A short sample and an overlong one, both dropped.
		push_data(5);
		append_byte(DELIM_BYTE);
		push_data(13);
		append_byte(DELIM_BYTE);
		// Several delimiters in a row after a full sample: one decode only.
		push_sample(8'h01, random_body());
		repeat (3) append_byte(DELIM_BYTE);
		// A sample closed by the end of the stream rather than a delimiter.
		append_byte(DELIM_BYTE);
		push_sample(8'h08, random_body());
		stream_ends = 1;
		send_pending();
		// A word of nothing but delimiters, then noise closed by stream ends.
		send_word(32'hbcbc_bcbc, 1'b0);
		send_word(32'hffff_ffff, 1'b1);
		send_word(32'h0000_0000, 1'b1);
	endtask

	initial begin
		logic [CHANNEL_W-1:0] phase_base [5];
		logic [WORD_W-1:0]    word;
		logic                 last;
		int                   p;

		words_if.valid      = 1'b0;
		words_if.fiber_word = '0;
		words_if.last_word  = 1'b0;
		results_if.ready    = 1'b0;
		stall_left          = 0;
		stream_ends         = 0;
		auto_segments       = 0;
		idle_on             = 1;
		framed_cap          = '0;
		phase_base          = '{4'd0, 4'd15, 4'd9, 4'd8, 4'd0};

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		write_channel_base(4'd8);
		directed_stream();

		// Random phases, each under its own channel base. The settings include
		// the largest legal offset and values that wrap past channel 15. The
		// last phase runs with no idling on either side.
		auto_segments = 1;
		for (p = 0; p < 5; p++) begin
			write_channel_base(phase_base[p]);
			if (p == 4) idle_on = 0;
			repeat (PHASE_WORDS) begin
				if ($urandom_range(0, 99) == 0) drain_results();
				next_word(word, last);
				send_word(word, last);
			end
		end

		drain_results();
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
